// File: rtl/spb_pkg.sv
// ---------------------------------------------------------------------------
// spb_pkg - shared definitions for the sprite pixel blender
// Frame geometry, configuration layout, command and register codes, the
// controller states and the effective view size helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spb_pkg;

   // frame geometry
   localparam int MAX_WIDTH   = 512;
   localparam int MAX_HEIGHT  = 256;
   localparam int X_BITS      = $clog2(MAX_WIDTH);
   localparam int Y_BITS      = $clog2(MAX_HEIGHT);
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

   // signed screen position, wide enough for every input combination
   localparam int POS_BITS = 19;

   // command codes
   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_PLOT  = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // register indexes
   localparam int CSR_IDX_BITS = 3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VIEW_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VIEW_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAMERA_X    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAMERA_Y    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FILL_COLOR  = 3'd4;

   // register reset values
   localparam logic [9:0]  VIEW_WIDTH_RST  = 10'd320;
   localparam logic [8:0]  VIEW_HEIGHT_RST = 9'd200;
   localparam logic [31:0] FILL_COLOR_RST  = 32'hFF00_0000;

   typedef struct packed {
      logic [9:0]         view_width;
      logic [8:0]         view_height;
      logic signed [15:0] camera_x;
      logic signed [15:0] camera_y;
      logic [31:0]        fill_color;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] sprite_x;
      logic signed [15:0] sprite_y;
      logic [11:0]        texel_col;
      logic [11:0]        texel_row;
      logic [31:0]        texel;
      logic [8:0]         read_x;
      logic [7:0]         read_y;
   } item_type;

   typedef struct packed {
      logic                 hit;
      logic [ADDR_BITS-1:0] addr;
   } coord_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CLEAR,
      ST_READ,
      ST_FETCH,
      ST_MIX,
      ST_DONE
   } state_type;

   function automatic logic [9:0] eff_width(input logic [9:0] vw);
      if (32'(vw) > MAX_WIDTH) return 10'(MAX_WIDTH);
      return vw;
   endfunction

   function automatic logic [8:0] eff_height(input logic [8:0] vh);
      if (32'(vh) > MAX_HEIGHT) return 9'(MAX_HEIGHT);
      return vh;
   endfunction

endpackage

`default_nettype wire

// File: rtl/spb_req_if.sv
// ---------------------------------------------------------------------------
// spb_req_if - command channel
// Valid/ready channel carrying one draw, clear or read command word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spb_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic signed [15:0] sprite_x;
   logic signed [15:0] sprite_y;
   logic [11:0]        texel_col;
   logic [11:0]        texel_row;
   logic [7:0]         red_in;
   logic [7:0]         green_in;
   logic [7:0]         blue_in;
   logic [7:0]         alpha_in;
   logic [8:0]         read_x;
   logic [7:0]         read_y;

   modport source (
      output valid, mode, sprite_x, sprite_y, texel_col, texel_row,
             red_in, green_in, blue_in, alpha_in, read_x, read_y,
      input  ready
   );

   modport sink (
      input  valid, mode, sprite_x, sprite_y, texel_col, texel_row,
             red_in, green_in, blue_in, alpha_in, read_x, read_y,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/spb_rsp_if.sv
// ---------------------------------------------------------------------------
// spb_rsp_if - result channel
// Valid/ready channel carrying the pixel word read or written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic [7:0] alpha_out;
   logic       in_view;

   modport source (
      output valid, red_out, green_out, blue_out, alpha_out, in_view,
      input  ready
   );

   modport sink (
      input  valid, red_out, green_out, blue_out, alpha_out, in_view,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/spb_csr_if.sv
// ---------------------------------------------------------------------------
// spb_csr_if - register write channel
// Valid/ready channel carrying a register index and its write data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spb_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/sprite_pixel_blender_unit.sv
// ---------------------------------------------------------------------------
// sprite_pixel_blender_unit - sprite framebuffer engine
// Clears the view, alpha-blends sprite texels into the frame buffer and
// reads pixels back, one command at a time.
// ---------------------------------------------------------------------------
// A command word is taken, decoded and run to completion before the next is
// taken; every command returns exactly one result word. A read passes through
// address decode, the frame buffer read, the fetch of the stored pixel and the
// hand-over into the result register; a plot adds the product register and
// then blend with write-back before the hand-over. A clear writes one pixel
// per cycle through the frame buffer write port over the effective view. An
// empty clear, an unused code or a position off the view goes from decode
// straight to the hand-over. The next command can be taken once the result
// register has loaded. A result waiting on the output does not hold up the
// next command, which proceeds until its own result is due. Pixels are packed
// red 7:0, green 15:8, blue 23:16, alpha 31:24; the frame buffer is not
// cleared by reset, so read a pixel only after a clear has covered it.
// Registers are to be written only while the unit is idle; the unit itself
// does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module sprite_pixel_blender_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   spb_req_if.sink    req_bus,
   spb_rsp_if.source  rsp_bus,
   spb_csr_if.sink    csr_bus
);

   localparam int AB = spb_pkg::ADDR_BITS;
   localparam int XB = spb_pkg::X_BITS;
   localparam int YB = spb_pkg::Y_BITS;

   // control state
   spb_pkg::state_type state_ff, state_in;
   spb_pkg::cfg_type   cfg_ff;
   logic [XB-1:0]      cx_ff;
   logic [YB-1:0]      cy_ff;
   logic               rsp_valid_ff;

   // command and working payload
   spb_pkg::item_type  item_ff;
   logic [AB-1:0]      addr_ff;
   logic               inside_ff;
   logic [31:0]        word_ff;
   logic [31:0]        rsp_word_ff;
   logic               rsp_inside_ff;

   // datapath nets
   spb_pkg::coord_type coord;
   logic [9:0]         w;
   logic [8:0]         h;
   logic               last_col;
   logic               last_row;
   logic [AB-1:0]      clear_addr;
   logic               rd_en;
   logic [31:0]        rd_data;
   logic               wr_en;
   logic [AB-1:0]      wr_addr;
   logic [31:0]        wr_data;
   logic               blend_load;
   logic [31:0]        blend_word;
   logic               rsp_load;
   logic               req_accept;

   // ------------------------------------------------------------------
   // submodules
   // ------------------------------------------------------------------
   spb_coord u_coord (
      .item  (item_ff),
      .cfg   (cfg_ff),
      .coord (coord)
   );

   spb_frame_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   spb_blend u_blend (
      .clock    (clock),
      .load     (blend_load),
      .old_word (rd_data),
      .texel    (item_ff.texel),
      .word     (blend_word)
   );

   // ------------------------------------------------------------------
   // clear walk position
   // ------------------------------------------------------------------
   assign w          = spb_pkg::eff_width(cfg_ff.view_width);
   assign h          = spb_pkg::eff_height(cfg_ff.view_height);
   assign last_col   = (32'(cx_ff) + 32'd1) == 32'(w);
   assign last_row   = (32'(cy_ff) + 32'd1) == 32'(h);
   assign clear_addr = AB'(cy_ff) * AB'(spb_pkg::MAX_WIDTH) + AB'(cx_ff);

   assign req_accept = req_bus.valid && req_bus.ready;

   // ------------------------------------------------------------------
   // controller
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) state_ff <= spb_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in      = state_ff;
      req_bus.ready = 1'b0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = blend_word;
      blend_load    = 1'b0;
      rsp_load      = 1'b0;
      unique case (state_ff)
         spb_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) state_in = spb_pkg::ST_DECODE;
         end
         spb_pkg::ST_DECODE: begin
            unique case (item_ff.mode)
               spb_pkg::MODE_CLEAR: begin
                  // empty view: nothing to fill
                  if (w == '0 || h == '0) state_in = spb_pkg::ST_DONE;
                  else                    state_in = spb_pkg::ST_CLEAR;
               end
               spb_pkg::MODE_PLOT, spb_pkg::MODE_READ: begin
                  state_in = coord.hit ? spb_pkg::ST_READ : spb_pkg::ST_DONE;
               end
               default: state_in = spb_pkg::ST_DONE;
            endcase
         end
         spb_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clear_addr;
            wr_data = cfg_ff.fill_color;
            if (last_col && last_row) state_in = spb_pkg::ST_DONE;
         end
         spb_pkg::ST_READ: begin
            rd_en    = 1'b1;
            state_in = spb_pkg::ST_FETCH;
         end
         spb_pkg::ST_FETCH: begin
            // stored pixel is on rd_data here
            if (item_ff.mode == spb_pkg::MODE_PLOT) begin
               blend_load = 1'b1;
               state_in   = spb_pkg::ST_MIX;
            end else begin
               state_in   = spb_pkg::ST_DONE;
            end
         end
         spb_pkg::ST_MIX: begin
            wr_en    = 1'b1;
            state_in = spb_pkg::ST_DONE;
         end
         spb_pkg::ST_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = spb_pkg::ST_IDLE;
            end
         end
         default: state_in = spb_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // clear counters
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
      end else if (state_ff == spb_pkg::ST_DECODE) begin
         cx_ff <= '0;
         cy_ff <= '0;
      end else if (state_ff == spb_pkg::ST_CLEAR) begin
         if (last_col) begin
            cx_ff <= '0;
            cy_ff <= cy_ff + YB'(1);
         end else begin
            cx_ff <= cx_ff + XB'(1);
         end
      end
   end

   // ------------------------------------------------------------------
   // command capture and working registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.mode      <= req_bus.mode;
         item_ff.sprite_x  <= req_bus.sprite_x;
         item_ff.sprite_y  <= req_bus.sprite_y;
         item_ff.texel_col <= req_bus.texel_col;
         item_ff.texel_row <= req_bus.texel_row;
         item_ff.texel     <= {req_bus.alpha_in, req_bus.blue_in,
                               req_bus.green_in, req_bus.red_in};
         item_ff.read_x    <= req_bus.read_x;
         item_ff.read_y    <= req_bus.read_y;
      end
      if (state_ff == spb_pkg::ST_DECODE) begin
         addr_ff   <= coord.addr;
         inside_ff <= coord.hit;
         word_ff   <= '0;
      end
      if (state_ff == spb_pkg::ST_FETCH && item_ff.mode == spb_pkg::MODE_READ) begin
         word_ff <= rd_data;
      end
      if (state_ff == spb_pkg::ST_MIX) begin
         word_ff <= blend_word;
      end
   end

   // ------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset)              rsp_valid_ff <= 1'b0;
      else if (rsp_load)      rsp_valid_ff <= 1'b1;
      else if (rsp_bus.ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_word_ff   <= word_ff;
         rsp_inside_ff <= inside_ff;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.red_out   = rsp_word_ff[7:0];
   assign rsp_bus.green_out = rsp_word_ff[15:8];
   assign rsp_bus.blue_out  = rsp_word_ff[23:16];
   assign rsp_bus.alpha_out = rsp_word_ff[31:24];
   assign rsp_bus.in_view   = rsp_inside_ff;

   // ------------------------------------------------------------------
   // configuration registers, always ready
   // ------------------------------------------------------------------
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.view_width  <= spb_pkg::VIEW_WIDTH_RST;
         cfg_ff.view_height <= spb_pkg::VIEW_HEIGHT_RST;
         cfg_ff.camera_x    <= '0;
         cfg_ff.camera_y    <= '0;
         cfg_ff.fill_color  <= spb_pkg::FILL_COLOR_RST;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            spb_pkg::CSR_VIEW_WIDTH:  cfg_ff.view_width  <= csr_bus.data[9:0];
            spb_pkg::CSR_VIEW_HEIGHT: cfg_ff.view_height <= csr_bus.data[8:0];
            spb_pkg::CSR_CAMERA_X:    cfg_ff.camera_x    <= csr_bus.data[15:0];
            spb_pkg::CSR_CAMERA_Y:    cfg_ff.camera_y    <= csr_bus.data[15:0];
            spb_pkg::CSR_FILL_COLOR:  cfg_ff.fill_color  <= csr_bus.data;
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/spb_frame_store.sv
// ---------------------------------------------------------------------------
// spb_frame_store - frame buffer memory
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spb_frame_store (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [spb_pkg::ADDR_BITS-1:0] wr_addr,
   input  wire logic [31:0]                   wr_data,
   input  wire logic                          rd_en,
   input  wire logic [spb_pkg::ADDR_BITS-1:0] rd_addr,
   output logic      [31:0]                   rd_data
);

   logic [31:0] mem [spb_pkg::STORE_DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/spb_coord.sv
// ---------------------------------------------------------------------------
// spb_coord - screen position mapper
// Maps a plot or read command to a frame address and a view hit flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spb_coord (
   input  wire spb_pkg::item_type  item,
   input  wire spb_pkg::cfg_type   cfg,
   output spb_pkg::coord_type      coord
);

   localparam int PB = spb_pkg::POS_BITS;
   localparam int AB = spb_pkg::ADDR_BITS;

   logic [9:0]           w;
   logic [8:0]           h;
   logic signed [PB-1:0] sx;
   logic signed [PB-1:0] sy;
   logic                 plot_in;
   logic                 read_in;
   logic [AB-1:0]        plot_addr;
   logic [AB-1:0]        read_addr;

   always_comb begin
      w = spb_pkg::eff_width(cfg.view_width);
      h = spb_pkg::eff_height(cfg.view_height);

      // world to screen, y axis flipped
      sx = PB'(item.sprite_x) + $signed(PB'(w[9:1])) - PB'(cfg.camera_x)
         + $signed(PB'(item.texel_col));
      sy = -PB'(item.sprite_y) + $signed(PB'(h[8:1])) + PB'(cfg.camera_y)
         + $signed(PB'(item.texel_row));

      plot_in = !sx[PB-1] && (sx[PB-2:0] < (PB-1)'(w))
             && !sy[PB-1] && (sy[PB-2:0] < (PB-1)'(h));
      plot_addr = AB'(sy[PB-2:0]) * AB'(spb_pkg::MAX_WIDTH) + AB'(sx[PB-2:0]);

      read_in   = (10'(item.read_x) < w) && (9'(item.read_y) < h);
      read_addr = AB'(item.read_y) * AB'(spb_pkg::MAX_WIDTH) + AB'(item.read_x);

      unique case (item.mode)
         spb_pkg::MODE_PLOT: begin
            coord.hit  = plot_in;
            coord.addr = plot_addr;
         end
         spb_pkg::MODE_READ: begin
            coord.hit  = read_in;
            coord.addr = read_addr;
         end
         default: begin
            coord.hit  = 1'b0;
            coord.addr = read_addr;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/spb_blend.sv
// ---------------------------------------------------------------------------
// spb_blend - alpha blend datapath
// Registered channel products, then divide by 255, sum and saturate.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spb_blend (
   input  wire logic        clock,
   input  wire logic        load,
   input  wire logic [31:0] old_word,
   input  wire logic [31:0] texel,
   output logic      [31:0] word
);

   logic [15:0] new_prod_ff [3];
   logic [15:0] old_prod_ff [3];
   logic [31:0] texel_ff;
   logic [31:0] old_ff;
   logic [7:0]  alpha;
   logic [8:0]  sum [3];
   logic [7:0]  chan [3];

   // exact floor(x / 255) for x up to 255 * 255, the largest channel product
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [15:0] t;
      t = x + (x >> 8) + 16'd1;
      return t[15:8];
   endfunction

   always_ff @(posedge clock) begin
      if (load) begin
         for (int c = 0; c < 3; c++) begin
            new_prod_ff[c] <= texel[8*c +: 8] * texel[31:24];
            old_prod_ff[c] <= old_word[8*c +: 8] * (8'd255 - texel[31:24]);
         end
         texel_ff <= texel;
         old_ff   <= old_word;
      end
   end

   always_comb begin
      alpha = texel_ff[31:24];
      for (int c = 0; c < 3; c++) begin
         sum[c]  = 9'(div255(new_prod_ff[c])) + 9'(div255(old_prod_ff[c]));
         chan[c] = sum[c][8] ? 8'hFF : sum[c][7:0];
      end
      if (alpha == 8'hFF)      word = texel_ff;
      else if (alpha == 8'h00) word = old_ff;
      else                     word = {alpha, chan[2], chan[1], chan[0]};
   end

endmodule

`default_nettype wire
